// ===== rtl/spdec_pkg.sv =====
// ----------------------------------------------------------------------------
// spdec_pkg
// Shared types and constants for the motor speed packet decoder.
// ----------------------------------------------------------------------------
package spdec_pkg;

  localparam logic [7:0]  HeaderByte  = 8'hFF;
  localparam logic [15:0] SpeedCenter = 16'h8000;
  localparam logic [15:0] DutyMax     = 16'hFFFE;

  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_HIGH   = 2'd1,
    POS_LOW    = 2'd2
  } frame_pos_e;

  typedef enum logic [1:0] {
    DIR_COAST   = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } direction_e;

  typedef struct packed {
    logic        fire;
    logic [15:0] duty;
    direction_e  direction;
  } frame_res_t;

endpackage

// ===== rtl/motor_speed_packet_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// motor_speed_packet_decoder_unit
// Decodes header/high/low byte frames into a direction and PWM duty.
// ----------------------------------------------------------------------------
// A low-byte beat goes through the input register, then the result register.
// Throughput: one byte beat per cycle, set by the input register feeding the
// frame logic and the single result register, unless a result is stalled.
// Reset: asynchronous, active low; framing waits for a header, speed high
// byte is zero, both pipeline registers are empty.
module motor_speed_packet_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        overrun_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] duty_o,
  output logic [1:0]  direction_o
);

  logic                  s1_valid_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_ovr_q;
  logic                  advance;
  spdec_pkg::frame_res_t res;

  logic                  out_valid_q;
  logic [15:0]           duty_q;
  spdec_pkg::direction_e dir_q;

  spdec_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_valid_i(s1_valid_q),
    .advance_i   (advance),
    .rx_byte_i   (s1_byte_q),
    .overrun_i   (s1_ovr_q),
    .res_o       (res)
  );

  // a beat that makes no result never waits on the output side
  assign advance    = s1_valid_q && (!res.fire || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
      s1_ovr_q  <= overrun_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.fire) begin
      duty_q <= res.duty;
      dir_q  <= res.direction;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign direction_o = dir_q;

  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> direction_o != 2'd3)
    else $error("illegal direction code");

  a_coast_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((duty_o == 16'd0) == (direction_o == spdec_pkg::DIR_COAST)))
    else $error("duty and coast disagree");

  a_duty_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_o <= spdec_pkg::DutyMax)
    else $error("duty not clamped");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && res.fire && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

endmodule

// ===== rtl/spdec_frame.sv =====
// ----------------------------------------------------------------------------
// spdec_frame
// Frame tracker and speed-to-duty conversion for one registered byte.
// ----------------------------------------------------------------------------
module spdec_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  beat_valid_i,
  input  logic                  advance_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  overrun_i,
  output spdec_pkg::frame_res_t res_o
);

  spdec_pkg::frame_pos_e pos_q, pos_d, pos_eff;
  logic [7:0]  speed_high_q, speed_high_d;
  logic [15:0] speed;
  logic [15:0] mag;
  logic [32:0] prod;
  logic [15:0] scaled;
  logic        fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= spdec_pkg::POS_HEADER;
      speed_high_q <= 8'd0;
    end else if (advance_i) begin
      pos_q        <= pos_d;
      speed_high_q <= speed_high_d;
    end
  end

  // overrun drops framing before the byte is looked at
  assign pos_eff = overrun_i ? spdec_pkg::POS_HEADER : pos_q;

  always_comb begin
    pos_d        = pos_eff;
    speed_high_d = speed_high_q;
    fire         = 1'b0;
    unique case (pos_eff)
      spdec_pkg::POS_HEADER: begin
        if (rx_byte_i == spdec_pkg::HeaderByte) pos_d = spdec_pkg::POS_HIGH;
      end
      spdec_pkg::POS_HIGH: begin
        speed_high_d = rx_byte_i;
        pos_d        = spdec_pkg::POS_LOW;
      end
      default: begin
        pos_d = spdec_pkg::POS_HEADER;
        fire  = beat_valid_i;
      end
    endcase
  end

  assign speed = {speed_high_q, rx_byte_i};

  always_comb begin
    if (speed > spdec_pkg::SpeedCenter) begin
      mag = speed - spdec_pkg::SpeedCenter;
    end else begin
      mag = spdec_pkg::SpeedCenter - speed;
    end
  end

  // mag * 65535 / 32768 as shift-and-subtract
  assign prod   = {1'b0, mag, 16'd0} - {17'd0, mag};
  assign scaled = prod[30:15];

  always_comb begin
    res_o.fire = fire;
    if (speed == spdec_pkg::SpeedCenter) begin
      res_o.duty      = 16'd0;
      res_o.direction = spdec_pkg::DIR_COAST;
    end else begin
      res_o.duty      = (prod[31] || scaled > spdec_pkg::DutyMax) ? spdec_pkg::DutyMax
                                                                 : scaled;
      res_o.direction = (speed > spdec_pkg::SpeedCenter) ? spdec_pkg::DIR_FORWARD
                                                         : spdec_pkg::DIR_REVERSE;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_speed_packet_decoder_unit. A directed table of
// byte beats (stop, full forward, full reverse, smallest magnitudes, dropped
// bytes, overrun restarts) is followed by random frames mixed with noise.
// Every accepted byte goes through a local frame decoder. The speed commands
// it predicts are queued and compared field by field with each result beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] PwmPeriod  = 32'd65535;
  localparam int          NumRandom  = 2000;
  localparam int          NumTable   = 28;
  localparam int          HoldCycles = 400;

  typedef struct packed {
    logic [15:0]           duty;
    spdec_pkg::direction_e dir;
  } speed_cmd_t;

  typedef struct packed {
    logic [7:0]            rx_byte;
    logic                  ovr;
    logic                  typed;
    logic [15:0]           duty;
    spdec_pkg::direction_e dir;
  } byte_vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        overrun_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] duty_o;
  logic [1:0]  direction_o;

  // Local copy of the framing state
  spdec_pkg::frame_pos_e frame_pos;
  logic [7:0]            speed_hi;

  speed_cmd_t  cmd_q[$];
  int          mismatches;
  int          beats_sent;
  int          burst_left;
  bit          tx_calm;
  bit          rx_calm;
  bit          hold_req;

  // Rows with typed = 1 carry a hand-computed result on their low byte
  byte_vec_t byte_table [0:NumTable-1] = '{
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h80, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h00, 1'b0, 1'b1, 16'd0,     spdec_pkg::DIR_COAST},    // exact stop
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},    // 0xFF as high byte
    '{8'hFF, 1'b0, 1'b1, 16'd65533, spdec_pkg::DIR_FORWARD},  // full forward
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h00, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h00, 1'b0, 1'b1, 16'd65534, spdec_pkg::DIR_REVERSE},  // full reverse, clamped
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h80, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h01, 1'b0, 1'b1, 16'd1,     spdec_pkg::DIR_FORWARD},
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h7F, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'hFF, 1'b0, 1'b1, 16'd1,     spdec_pkg::DIR_REVERSE},
    '{8'h12, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},    // no header, dropped
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h12, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h34, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'hFF, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h90, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'hFF, 1'b1, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},    // overrun, restarts
    '{8'h40, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h00, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h55, 1'b1, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},    // overrun, non-header
    '{8'hFF, 1'b1, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'hC0, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST},
    '{8'h00, 1'b0, 1'b0, 16'd0,     spdec_pkg::DIR_COAST}
  };

  motor_speed_packet_decoder_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .overrun_i  (overrun_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .duty_o     (duty_o),
    .direction_o(direction_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Advances the local framing by one byte; returns 1 when a frame completes
  function automatic bit decode_byte(input logic [7:0] rx_byte, input logic ovr,
                                     output speed_cmd_t cmd);
    logic [15:0] speed;
    logic [31:0] mag;
    logic [31:0] scaled;
    cmd.duty = 16'd0;
    cmd.dir  = spdec_pkg::DIR_COAST;
    if (ovr) frame_pos = spdec_pkg::POS_HEADER;
    case (frame_pos)
      spdec_pkg::POS_HEADER: begin
        if (rx_byte == spdec_pkg::HeaderByte) frame_pos = spdec_pkg::POS_HIGH;
        return 1'b0;
      end
      spdec_pkg::POS_HIGH: begin
        speed_hi  = rx_byte;
        frame_pos = spdec_pkg::POS_LOW;
        return 1'b0;
      end
      default: begin
        frame_pos = spdec_pkg::POS_HEADER;
        speed = {speed_hi, rx_byte};
        if (speed == spdec_pkg::SpeedCenter) return 1'b1;
        if (speed > spdec_pkg::SpeedCenter) begin
          mag     = {16'd0, speed - spdec_pkg::SpeedCenter};
          cmd.dir = spdec_pkg::DIR_FORWARD;
        end else begin
          mag     = {16'd0, spdec_pkg::SpeedCenter - speed};
          cmd.dir = spdec_pkg::DIR_REVERSE;
        end
        scaled = (mag * PwmPeriod) / {16'd0, spdec_pkg::SpeedCenter};
        cmd.duty = (scaled >= PwmPeriod) ? spdec_pkg::DutyMax : scaled[15:0];
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // One byte beat: idle gap, hold valid until accepted, then predict
  task automatic send_beat(input logic [7:0] rx_byte, input logic ovr,
                           input logic typed, input speed_cmd_t typed_cmd);
    int         gap;
    speed_cmd_t cmd;
    if (beats_sent % 128 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = tx_calm ? 0 : $urandom_range(0, 17);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx_byte;
    overrun_i  <= ovr;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_byte(rx_byte, ovr, cmd)) cmd_q.push_back(typed ? typed_cmd : cmd);
    beats_sent++;
  endtask

  // Result side
  initial begin
    int         gap;
    int         beats_seen;
    speed_cmd_t want;
    out_ready_i = 1'b0;
    beats_seen  = 0;
    @(posedge rst_ni);
    forever begin
      if (beats_seen % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 17);
      end
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats_seen++;
      if (cmd_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result duty=%0d dir=%0d",
                                  duty_o, direction_o));
      end else begin
        want = cmd_q.pop_front();
        if (duty_o !== want.duty)
          report_mismatch($sformatf("duty %0d, expected %0d", duty_o, want.duty));
        if (direction_o !== want.dir)
          report_mismatch($sformatf("direction %0d, expected %0d",
                                    direction_o, want.dir));
      end
    end
  end

  // Stimulus
  initial begin
    speed_cmd_t  tc;
    logic [15:0] speed;
    int          n;
    bit          hold_done;
    bit          drain_done;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    overrun_i  = 1'b0;
    rst_ni     = 1'b0;
    frame_pos  = spdec_pkg::POS_HEADER;
    speed_hi   = 8'h00;
    mismatches = 0;
    beats_sent = 0;
    burst_left = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumTable; i++) begin
      tc.duty = byte_table[i].duty;
      tc.dir  = byte_table[i].dir;
      send_beat(byte_table[i].rx_byte, byte_table[i].ovr, byte_table[i].typed, tc);
    end

    tc = '0;
    while (beats_sent < NumTable + NumRandom) begin
      // Output held off while bytes keep coming back to back
      if (!hold_done && beats_sent >= 600) begin
        hold_done  = 1'b1;
        hold_req   = 1'b1;
        burst_left = 200;
      end
      // Input goes quiet until the pipe is empty
      if (!drain_done && beats_sent >= 1300) begin
        drain_done = 1'b1;
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait (cmd_q.size() == 0);
      end
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 7))
          0: speed = {($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F, 8'($urandom)};
          1: speed = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(16'hFFFC, 16'hFFFF))
                                                 : 16'($urandom_range(0, 3));
          default: speed = 16'($urandom);
        endcase
        send_beat(spdec_pkg::HeaderByte, ($urandom_range(0, 15) == 0), 1'b0, tc);
        send_beat(speed[15:8], ($urandom_range(0, 31) == 0), 1'b0, tc);
        send_beat(speed[7:0], ($urandom_range(0, 31) == 0), 1'b0, tc);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_beat(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, tc);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (cmd_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && cmd_q.size() == 0) begin
      $display("motor_speed_packet_decoder_unit test passed");
    end else begin
      $display("motor_speed_packet_decoder_unit test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("motor_speed_packet_decoder_unit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spdec_pkg.sv
rtl/spdec_frame.sv
rtl/motor_speed_packet_decoder_unit.sv
tb/testbench.sv
